// ===== rtl/combined_lcg_shuffle_rng_core_assert.svh =====
// Assertion macros shared by the checker of the combined generator core.
// No dependencies; take in by `include before the module that asserts.
`ifndef COMBINED_LCG_SHUFFLE_RNG_CORE_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_CORE_ASSERT_SVH

// Concurrent assertion on a given clock and active-low reset.
`define CLSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the core's own clock and reset names.
`define CLSR_ASSERT_CORE(lbl, prop, msg) \
    `CLSR_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/clsr_pkg.sv =====
// Package for the combined generator core: constants, state enum, table control struct.
// Used by every module of the core; no dependencies.
package clsr_pkg;

    localparam int VW = 31;
    localparam int MW = 16;
    localparam int PW = VW + MW;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int WARM_EXTRA          = 8;

    localparam logic [VW-1:0] MOD_ONE   = 31'd2147483563;
    localparam logic [VW-1:0] MOD_TWO   = 31'd2147483399;
    localparam logic [MW-1:0] MUL_ONE   = 16'd40014;
    localparam logic [MW-1:0] MUL_TWO   = 16'd40692;
    localparam logic [VW-1:0] TOP_VALUE = 31'd2147483562;
    localparam logic [VW-1:0] G1_RESET  = 31'd1;
    localparam logic [VW-1:0] G2_RESET  = 31'd123456789;

    // 2^31 mod modulus, used to fold the high part of a product
    localparam logic [7:0] FOLD_ONE = 8'((64'd1 << VW) - 64'(MOD_ONE));
    localparam logic [7:0] FOLD_TWO = 8'((64'd1 << VW) - 64'(MOD_TWO));

    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WARM_MUL,
        S_WARM_RED,
        S_MUL,
        S_RED,
        S_RD,
        S_WR
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tab_ctl;

    // Reduce a product below 2^47 modulo m, where 2^31 mod m = f and m > 2^31 - 2^8.
    function automatic logic [VW-1:0] fold(input logic [PW-1:0] p, input logic [7:0] f,
                                           input logic [VW-1:0] m);
        logic [31:0] s;
        s = 32'(p[PW-1:VW]) * 32'(f) + 32'(p[VW-1:0]);
        if (s >= 32'(m)) begin
            s = s - 32'(m);
        end
        return s[VW-1:0];
    endfunction

endpackage

// ===== rtl/combined_lcg_shuffle_rng_core.sv =====
// Combined multiplicative generator with shuffle table: control, generator state, output register.
// Depends on clsr_pkg, clsr_step, clsr_slot, clsr_table.
//
//   channel | direction | handshake                | fields
//   in      | to core   | i_in_valid / o_in_stall  | i_func, i_seed
//   out     | from core | o_out_valid / i_out_stall| o_value
//
// A draw steps through product, fold, slot read and table write; the next item is taken
// in the write cycle, so a new draw can start as the last one completes.
// A reseed first runs a warm-up that fills the table through the shared multiply unit.
// A held output stalls the write cycle; the table and last output update only when it moves.
// Reset is synchronous: generators, last output and all table entries return to start values.
module combined_lcg_shuffle_rng_core import clsr_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_func,
    input  logic [VW-1:0] i_seed,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [VW-1:0] o_value
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + WARM_EXTRA);

    t_state        r_state;
    t_state        n_state;
    logic [VW-1:0] r_g1;
    logic [VW-1:0] r_g2;
    logic [VW-1:0] r_last;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_slot;
    logic [VW-1:0] r_value;
    logic          r_out_valid;

    logic          accept;
    logic          wr_go;
    logic          step_load;
    logic          slot_load;
    t_tab_ctl      tab_ctl;
    logic [AW-1:0] tab_waddr;
    logic [VW-1:0] tab_wdata;
    logic [AW-1:0] slot;
    logic [VW-1:0] tab_rdata;
    logic [VW-1:0] step_g1;
    logic [VW-1:0] step_g2;
    logic [VW-1:0] seed_eff;
    logic [31:0]   diff;
    logic [VW-1:0] draw_value;

    clsr_step u_step (
        .i_clk  (i_clk),
        .i_load (step_load),
        .i_g1   (r_g1),
        .i_g2   (r_g2),
        .o_g1   (step_g1),
        .o_g2   (step_g2)
    );

    clsr_slot #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_slot (
        .i_clk  (i_clk),
        .i_load (slot_load),
        .i_last (r_last),
        .o_slot (slot)
    );

    clsr_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tab_ctl),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (slot),
        .o_rdata (tab_rdata)
    );

    assign wr_go      = (r_state == S_WR) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == S_IDLE) || wr_go);
    assign accept     = i_in_valid && !o_in_stall;
    assign seed_eff   = (i_seed == '0) ? VW'(1) : i_seed;

    always_comb begin
        diff = 32'(tab_rdata) - 32'(r_g2);
        if (tab_rdata > r_g2) begin
            draw_value = diff[VW-1:0];
        end else begin
            draw_value = VW'(diff + 32'(TOP_VALUE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        step_load     = 1'b0;
        slot_load     = 1'b0;
        tab_ctl.wr_en = 1'b0;
        tab_ctl.rd_en = 1'b0;
        tab_waddr     = r_slot;
        tab_wdata     = r_g1;
        unique case (r_state)
            S_IDLE, S_WR: begin
                if (r_state == S_WR) begin
                    tab_ctl.wr_en = wr_go;
                    if (wr_go) begin
                        n_state = S_IDLE;
                    end
                end
                if (accept) begin
                    n_state = (i_func == FUNC_RESEED) ? S_WARM_MUL : S_MUL;
                end
            end
            S_WARM_MUL: begin
                step_load = 1'b1;
                n_state   = S_WARM_RED;
            end
            S_WARM_RED: begin
                tab_ctl.wr_en = (r_cnt < CW'(TABLE_DEPTH));
                tab_waddr     = r_cnt[AW-1:0];
                tab_wdata     = step_g1;
                n_state       = (r_cnt == '0) ? S_MUL : S_WARM_MUL;
            end
            S_MUL: begin
                step_load = 1'b1;
                slot_load = 1'b1;
                n_state   = S_RED;
            end
            S_RED: begin
                n_state = S_RD;
            end
            S_RD: begin
                tab_ctl.rd_en = 1'b1;
                n_state       = S_WR;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1   <= G1_RESET;
            r_g2   <= G2_RESET;
            r_last <= '0;
        end else begin
            if (wr_go) begin
                r_last <= draw_value;
            end
            if (accept && (i_func == FUNC_RESEED)) begin
                r_g1 <= seed_eff;
                r_g2 <= seed_eff;
            end
            if (r_state == S_WARM_RED) begin
                r_g1 <= step_g1;
                if (r_cnt == '0) begin
                    r_last <= step_g1;
                end
            end
            if (r_state == S_RED) begin
                r_g1 <= step_g1;
                r_g2 <= step_g2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt <= CW'(TABLE_DEPTH + WARM_EXTRA - 1);
        end else if (r_state == S_WARM_RED) begin
            r_cnt <= r_cnt - CW'(1);
        end
        if (r_state == S_RD) begin
            r_slot <= slot;
        end
        if (wr_go) begin
            r_value <= draw_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

endmodule

// ===== rtl/clsr_step.sv =====
// Two-lane modular multiply unit: product register, then fold and one subtract.
// Depends on clsr_pkg.
module clsr_step import clsr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [VW-1:0] i_g1,
    input  logic [VW-1:0] i_g2,
    output logic [VW-1:0] o_g1,
    output logic [VW-1:0] o_g2
);

    logic [PW-1:0] r_p1;
    logic [PW-1:0] r_p2;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p1 <= PW'(i_g1) * PW'(MUL_ONE);
            r_p2 <= PW'(i_g2) * PW'(MUL_TWO);
        end
    end

    assign o_g1 = fold(r_p1, FOLD_ONE, MOD_ONE);
    assign o_g2 = fold(r_p2, FOLD_TWO, MOD_TWO);

endmodule

// ===== rtl/clsr_slot.sv =====
// Table slot from the last output: reciprocal multiply, back-multiply, one correction.
// Depends on clsr_pkg.
module clsr_slot import clsr_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [VW-1:0] i_last,
    output logic [AW-1:0] o_slot
);

    localparam longint unsigned DIV   = 1 + 64'(TOP_VALUE) / TABLE_DEPTH;
    localparam longint unsigned RECIP = (64'd1 << 32) / DIV;
    localparam int              QW    = $clog2(TABLE_DEPTH + 1) + 1;

    logic [VW-1:0] r_x;
    logic [QW-1:0] r_qe;
    logic [VW-1:0] r_qd;
    logic [VW-1:0] rem;
    logic [QW-1:0] q;

    // estimate is the true quotient or one below
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x  <= i_last;
            r_qe <= QW'((64'(i_last) * RECIP) >> 32);
        end
        r_qd <= VW'(64'(r_qe) * DIV);
    end

    always_comb begin
        rem = r_x - r_qd;
        q   = r_qe + QW'(rem >= VW'(DIV));
        if (q > QW'(TABLE_DEPTH - 1)) begin
            o_slot = AW'(TABLE_DEPTH - 1);
        end else begin
            o_slot = AW'(q);
        end
    end

endmodule

// ===== rtl/clsr_table.sv =====
// Shuffle table memory: one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero. Depends on clsr_pkg.
module clsr_table import clsr_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tab_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  logic [VW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [VW-1:0] o_rdata
);

    logic [VW-1:0]          r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [VW-1:0]          r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/clsr_checker.sv =====
// Port-level checker for the combined generator core, bound to the top level.
// Depends on clsr_pkg and combined_lcg_shuffle_rng_core_assert.svh.
`include "combined_lcg_shuffle_rng_core_assert.svh"

module clsr_checker import clsr_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic [VW-1:0] o_value
);

    `CLSR_ASSERT_CORE(a_value_range, o_out_valid |-> (o_value != '0) && (o_value <= TOP_VALUE), "item value out of range")
    `CLSR_ASSERT_CORE(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall, "core not busy after item taken")
    `CLSR_ASSERT_CORE(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_value)), "stalled output item changed")
    `CLSR_ASSERT_CORE(a_draw_latency, $rose(o_out_valid) |-> ($past(o_in_stall, 2) && $past(o_in_stall, 3)), "output item too early")

endmodule

bind combined_lcg_shuffle_rng_core clsr_checker u_clsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value)
);

// ===== verif/combined_lcg_shuffle_rng_core_tb.sv =====
// Testbench for combined_lcg_shuffle_rng_core: directed and randomised draws and reseeds, every result
// checked against an in-bench model of the two generators and the shuffle table.
// Depends on clsr_pkg and the RTL of the core.
module combined_lcg_shuffle_rng_core_tb;
    import clsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH      = DEFAULT_TABLE_DEPTH;
    localparam longint     SLOT_WIDTH = 1 + longint'(TOP_VALUE) / DEPTH;
    localparam int         N_RANDOM   = 1130;
    localparam int         STALL_MAX  = 2000;
    localparam logic [VW-1:0] SEED_MAX = {VW{1'b1}};

    typedef struct {
        logic          func;
        logic [VW-1:0] seed;
        bit            calm;
        bit            drain;
    } t_rng_req;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_func      = FUNC_DRAW;
    logic [VW-1:0] i_seed      = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [VW-1:0] o_value;

    t_rng_req      req_q[$];
    logic [VW-1:0] values_due[$];

    logic [VW-1:0] gen_a;
    logic [VW-1:0] gen_b;
    logic [VW-1:0] prev_value;
    logic [VW-1:0] shuffle_mem[DEPTH];

    bit in_taken;
    bit out_taken;
    bit calm_now;
    int gap_left;
    int hold_left;
    int quiet_cycles;
    int fail_cnt;

    combined_lcg_shuffle_rng_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_seed     (i_seed),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_value    (o_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [VW-1:0] lcg_one(input logic [VW-1:0] x);
        return VW'((64'(MUL_ONE) * 64'(x)) % 64'(MOD_ONE));
    endfunction

    function automatic logic [VW-1:0] lcg_two(input logic [VW-1:0] x);
        return VW'((64'(MUL_TWO) * 64'(x)) % 64'(MOD_TWO));
    endfunction

    function automatic logic [VW-1:0] next_value(input logic func, input logic [VW-1:0] seed);
        longint        diff;
        longint        slot;
        logic [VW-1:0] s;
        if (func == FUNC_RESEED) begin
            s = (seed == '0) ? VW'(1) : seed;
            gen_a = s;
            gen_b = s;
            for (int k = DEPTH + WARM_EXTRA - 1; k >= 0; k--) begin
                gen_a = lcg_one(gen_a);
                if (k < DEPTH) begin
                    shuffle_mem[k] = gen_a;
                end
            end
            prev_value = shuffle_mem[0];
        end
        gen_a = lcg_one(gen_a);
        gen_b = lcg_two(gen_b);
        slot = longint'(prev_value) / SLOT_WIDTH;
        if (slot >= DEPTH) begin
            slot = DEPTH - 1;
        end
        diff = longint'(shuffle_mem[slot]) - longint'(gen_b);
        shuffle_mem[slot] = gen_a;
        if (diff < 1) begin
            diff = diff + longint'(TOP_VALUE);
        end
        prev_value = VW'(diff);
        return prev_value;
    endfunction

    function automatic void add_req(input logic func, input logic [VW-1:0] seed,
                                    input bit calm, input bit drain);
        t_rng_req r;
        r.func  = func;
        r.seed  = seed;
        r.calm  = calm;
        r.drain = drain;
        req_q.push_back(r);
    endfunction

    // item driver
    always @(negedge i_clk) begin
        t_rng_req r;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0 && !(req_q[0].drain && values_due.size() != 0)) begin
                r = req_q.pop_front();
                i_func     <= r.func;
                i_seed     <= r.seed;
                i_in_valid <= 1'b1;
                calm_now    = r.calm;
                if (!r.calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 18);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!calm_now && $urandom_range(0, 11) == 0) begin
            hold_left = $urandom_range(1, 18) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        logic [VW-1:0] want;
        in_taken  = i_rst_n && i_in_valid && !o_in_stall;
        out_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (out_taken) begin
            if (values_due.size() == 0) begin
                $error("unexpected item: value actual %0d", o_value);
                fail_cnt++;
            end else begin
                want = values_due.pop_front();
                if (o_value !== want) begin
                    $error("value mismatch: expected %0d actual %0d", want, o_value);
                    fail_cnt++;
                end
            end
        end
        if (in_taken) begin
            values_due.push_back(next_value(i_func, i_seed));
        end
        if (in_taken || out_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [VW-1:0] s;
        bit            calm;
        gen_a      = G1_RESET;
        gen_b      = G2_RESET;
        prev_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            shuffle_mem[k] = '0;
        end

        // draws straight out of reset, then reseed corner cases
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_DRAW,   SEED_MAX,          0, 0);
        add_req(FUNC_DRAW,   VW'(12345),        0, 0);
        add_req(FUNC_RESEED, '0,                0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_DRAW,   SEED_MAX,          0, 0);
        add_req(FUNC_RESEED, VW'(1),            0, 1);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_RESEED, TOP_VALUE,         0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_RESEED, MOD_ONE,           0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_DRAW,   SEED_MAX,          0, 0);
        add_req(FUNC_RESEED, SEED_MAX,          0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_RESEED, MOD_TWO,           0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);
        add_req(FUNC_RESEED, VW'(123456789),    0, 0);
        add_req(FUNC_DRAW,   '0,                0, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= N_RANDOM - 150) || (n >= 400 && n < 480);
            s = VW'($urandom);
            if ($urandom_range(0, 24) == 0) begin
                case ($urandom_range(0, 7))
                    0:       s = '0;
                    1:       s = VW'($urandom_range(MOD_ONE, SEED_MAX));
                    2:       s = VW'($urandom_range(1, 64));
                    default: ;
                endcase
                add_req(FUNC_RESEED, s, calm, n == 600);
            end else begin
                add_req(FUNC_DRAW, s, calm, n == 600);
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (values_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
